// ----- sv/assert_macros.svh -----
// Assertion helpers for the RTL, included by atfp_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// prop must hold at every edge out of reset
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// expr must never be true out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

// ----- sv/atfp_pkg.sv -----
`default_nettype none
package atfp_pkg;
	localparam int ADC_W      = 12;
	localparam int DEG_W      = 9;
	localparam int PROD_W     = ADC_W + DEG_W;
	localparam int TEMP_W     = 8;
	localparam int TRIG_W     = 7;
	localparam int DIVR_W     = 8;
	localparam int DUTY_PROD_W = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam int DEG_SCALE  = 330;
	localparam int ADC_FULL   = 4095;
	localparam int TEMP_SAT   = 255;

	localparam logic [TRIG_W-1:0] TRIGGER_RST = 7'd20;
	localparam logic [TEMP_W-1:0] MAX_RST     = 8'd30;
	localparam logic [TEMP_W-1:0] KICK_RST    = 8'd35;
	localparam logic [TEMP_W-1:0] FULL_RST    = 8'd50;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TRIGGER = 2'd0,
		REG_MAX     = 2'd1,
		REG_KICK    = 2'd2,
		REG_FULL    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [TRIG_W-1:0] trigger;
		logic [TEMP_W-1:0] max_t;
		logic [TEMP_W-1:0] kick;
		logic [TEMP_W-1:0] full;
	} cfg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;
endpackage
`default_nettype wire

// ----- sv/atfp_front.sv -----
`default_nettype none
module atfp_front #(
	parameter int AVG_COUNT = 30,
	parameter int SUM_W     = 14
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [atfp_pkg::ADC_W-1:0]  adc_sample,
	input  logic                        fifo_full,
	output logic                        fifo_push,
	output logic [SUM_W-1:0]            fifo_wdata
);
	import atfp_pkg::*;

	localparam int CNT_W = $clog2(AVG_COUNT + 1);

	logic              vld_s1;
	logic [PROD_W-1:0] prod_s1;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DEG_W-1:0]  q0;
	logic [ADC_W:0]    rem;
	logic [DEG_W-1:0]  deg;
	logic [SUM_W-1:0]  sum_nx;
	logic              last;
	logic              adv;

	// x/4095 = q0 + carry, with x = 4096*q0 + lo; lo + q0 stays below 2*4095
	assign q0     = prod_s1[PROD_W-1:ADC_W];
	assign rem    = {1'b0, prod_s1[ADC_W-1:0]} + (ADC_W+1)'(q0);
	assign deg    = q0 + DEG_W'(rem >= (ADC_W+1)'(ADC_FULL));
	assign sum_nx = sum_q + SUM_W'(deg);
	assign last   = (cnt_q == CNT_W'(AVG_COUNT - 1));
	assign adv    = !(vld_s1 && last && fifo_full);

	assign in_stall   = !adv;
	assign fifo_push  = vld_s1 && last && !fifo_full;
	assign fifo_wdata = sum_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			sum_q  <= '0;
			cnt_q  <= '0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			if (vld_s1) begin
				if (last) begin
					sum_q <= '0;
					cnt_q <= '0;
				end else begin
					sum_q <= sum_nx;
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			prod_s1 <= PROD_W'(adc_sample) * PROD_W'(DEG_SCALE);
		end
	end
endmodule
`default_nettype wire

// ----- sv/atfp_fifo.sv -----
`default_nettype none
module atfp_fifo #(
	parameter int WIDTH = 14
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);
	logic [WIDTH-1:0] mem [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)      cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= wdata;
	end
endmodule
`default_nettype wire

// ----- sv/atfp_div.sv -----
`default_nettype none
module atfp_div #(
	parameter int DIV_W = 17
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [DIV_W-1:0]            dividend,
	input  logic [atfp_pkg::DIVR_W-1:0] divisor,
	output logic [DIV_W-1:0]            quotient,
	output atfp_pkg::div_stat_t         stat
);
	import atfp_pkg::*;

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0]  quo_q;
	logic [DIVR_W-1:0] rem_q;
	logic [DIVR_W-1:0] dvs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIVR_W:0]   rem_sh;
	logic [DIVR_W:0]   diff;
	logic              fits;

	// restoring divide, one quotient bit per cycle
	assign rem_sh = {rem_q, quo_q[DIV_W-1]};
	assign diff   = rem_sh - {1'b0, dvs_q};
	assign fits   = (rem_sh >= {1'b0, dvs_q});

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], fits};
			rem_q <= fits ? diff[DIVR_W-1:0] : rem_sh[DIVR_W-1:0];
		end
	end
endmodule
`default_nettype wire

// ----- sv/atfp_back.sv -----
`default_nettype none
`include "assert_macros.svh"
module atfp_back #(
	parameter int AVG_COUNT = 30,
	parameter int SUM_W     = 14,
	parameter int DIV_W     = 17
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  atfp_pkg::cfg_t              cfg,
	input  logic                        fifo_empty,
	input  logic [SUM_W-1:0]            fifo_rdata,
	output logic                        fifo_pop,
	output logic                        div_start,
	output logic [DIV_W-1:0]            div_dividend,
	output logic [atfp_pkg::DIVR_W-1:0] div_divisor,
	input  logic [DIV_W-1:0]            div_quotient,
	input  atfp_pkg::div_stat_t         div_stat,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [atfp_pkg::TEMP_W-1:0] reported_temp,
	output logic [atfp_pkg::TEMP_W-1:0] duty_compare,
	output logic                        motor_running,
	output logic                        pwm_enabled
);
	import atfp_pkg::*;

	// sum/AVG_COUNT as (sum*RCP_M) >> RCP_SH, exact for any sum below 2**SUM_W
	localparam int RCP_SH = SUM_W + $clog2(AVG_COUNT);
	localparam int RCP_W  = SUM_W + 1;
	localparam int RCP_M  = ((1 << RCP_SH) + AVG_COUNT - 1) / AVG_COUNT;
	localparam int AVGP_W = SUM_W + RCP_W;

	typedef enum logic [2:0] {ST_IDLE, ST_AVG, ST_DEC, ST_MUL, ST_DUTY, ST_EMIT} state_t;

	state_t            state_q;
	logic              motor_q;
	logic              timer_q;
	logic [SUM_W-1:0]  sum_q;
	logic [TEMP_W-1:0] avg_q;
	logic [TEMP_W-1:0] temp_q;
	logic [TEMP_W-1:0] duty_q;
	logic              start_q;
	logic [DIV_W-1:0]  dividend_q;
	logic [DIVR_W-1:0] divisor_q;
	logic              out_valid_q;
	logic [TEMP_W-1:0] out_temp_q;
	logic [TEMP_W-1:0] out_duty_q;
	logic              out_motor_q;
	logic              out_timer_q;

	logic [AVGP_W-1:0] avg_prod;
	logic [SUM_W-1:0]  avg_quo;
	logic [TEMP_W-1:0] avg;
	logic [TEMP_W-1:0] trig8;
	logic              above;
	logic [TEMP_W-1:0] clamped;
	logic [TEMP_W-1:0] span;
	logic [DUTY_PROD_W-1:0] duty_prod;

	assign avg_prod  = AVGP_W'(sum_q) * AVGP_W'(RCP_M);
	assign avg_quo   = SUM_W'(avg_prod >> RCP_SH);
	assign avg       = (avg_quo > SUM_W'(TEMP_SAT)) ? TEMP_W'(TEMP_SAT)
	                                                : avg_quo[TEMP_W-1:0];
	assign trig8     = {1'b0, cfg.trigger};
	assign above     = (avg_q > trig8);
	assign clamped   = (avg_q > cfg.max_t) ? cfg.max_t : avg_q;
	assign span      = cfg.max_t - trig8;
	assign duty_prod = DUTY_PROD_W'(temp_q - trig8) * DUTY_PROD_W'(cfg.full);

	assign fifo_pop      = (state_q == ST_IDLE) && !fifo_empty;
	assign div_start     = start_q;
	assign div_dividend  = dividend_q;
	assign div_divisor   = divisor_q;
	assign out_valid     = out_valid_q;
	assign reported_temp = out_temp_q;
	assign duty_compare  = out_duty_q;
	assign motor_running = out_motor_q;
	assign pwm_enabled   = out_timer_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			motor_q     <= 1'b0;
			timer_q     <= 1'b0;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (!out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (!fifo_empty) begin
						sum_q   <= fifo_rdata;
						state_q <= ST_AVG;
					end
				end
				ST_AVG: begin
					avg_q   <= avg;
					state_q <= ST_DEC;
				end
				ST_DEC: begin
					if (!above) begin
						motor_q <= 1'b0;
						temp_q  <= avg_q;
						duty_q  <= '0;
						state_q <= ST_EMIT;
					end else if (!motor_q) begin
						// first drive above trigger: kick start
						motor_q <= 1'b1;
						timer_q <= 1'b1;
						temp_q  <= avg_q;
						duty_q  <= cfg.kick;
						state_q <= ST_EMIT;
					end else begin
						timer_q <= 1'b1;
						temp_q  <= clamped;
						if (trig8 >= cfg.max_t) begin
							duty_q  <= cfg.full;
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					start_q    <= 1'b1;
					dividend_q <= DIV_W'(duty_prod);
					divisor_q  <= span;
					state_q    <= ST_DUTY;
				end
				ST_DUTY: begin
					if (div_stat.done) begin
						duty_q  <= div_quotient[TEMP_W-1:0];
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_temp_q  <= temp_q;
						out_duty_q  <= duty_q;
						out_motor_q <= motor_q;
						out_timer_q <= timer_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`ASSERT_NEVER(a_stop_has_duty, clk, arst_n, out_valid_q && !out_motor_q && (out_duty_q != '0), "stopped motor with nonzero duty")
	`ASSERT_NEVER(a_run_no_timer, clk, arst_n, out_valid_q && out_motor_q && !out_timer_q, "motor running with timer off")
	`ASSERT_NEVER(a_start_busy, clk, arst_n, start_q && div_stat.busy, "divider restarted while busy")
endmodule
`default_nettype wire

// ----- sv/averaged_temp_fan_pwm_control_top.sv -----
`default_nettype none
// Averaging temperature-to-fan-PWM controller. Each accepted adc_sample is
// scaled to whole degrees (floor(sample*330/4095)) and summed; every AVG_COUNT
// samples the sum is queued, and the back end divides it by AVG_COUNT with a
// reciprocal multiply, picks the duty (off, kick, or a linear map between the
// trigger and the full-speed temperature onto full_duty) and delivers one
// result. Samples can be taken one per clock; the input stalls only while the
// last sample of a group waits for room in the two-entry sum queue. A result
// passes the average and decide states, then goes to emit (off, kick or full
// duty) or through multiply and the bit-serial duty divider, DIV_W = 16.
// The configuration port never stalls; write it only while no group is in
// progress.
module averaged_temp_fan_pwm_control_top #(
	parameter int AVG_COUNT = 30
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [atfp_pkg::ADC_W-1:0]      adc_sample,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [atfp_pkg::TEMP_W-1:0]     reported_temp,
	output logic [atfp_pkg::TEMP_W-1:0]     duty_compare,
	output logic                            motor_running,
	output logic                            pwm_enabled,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [atfp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [atfp_pkg::CFG_DATA_W-1:0] cfg_data
);
	import atfp_pkg::*;

	localparam int SUM_W = $clog2(DEG_SCALE * AVG_COUNT + 1);
	localparam int DIV_W = DUTY_PROD_W;

	cfg_t              cfg_q;
	logic              fifo_full;
	logic              fifo_empty;
	logic              fifo_push;
	logic              fifo_pop;
	logic [SUM_W-1:0]  fifo_wdata;
	logic [SUM_W-1:0]  fifo_rdata;
	logic              div_start;
	logic [DIV_W-1:0]  div_dividend;
	logic [DIVR_W-1:0] div_divisor;
	logic [DIV_W-1:0]  div_quotient;
	div_stat_t         div_stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trigger <= TRIGGER_RST;
			cfg_q.max_t   <= MAX_RST;
			cfg_q.kick    <= KICK_RST;
			cfg_q.full    <= FULL_RST;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_TRIGGER: cfg_q.trigger <= cfg_data[TRIG_W-1:0];
				REG_MAX:     cfg_q.max_t   <= cfg_data;
				REG_KICK:    cfg_q.kick    <= cfg_data;
				REG_FULL:    cfg_q.full    <= cfg_data;
				default:     cfg_q         <= cfg_q;
			endcase
		end
	end

	atfp_front #(.AVG_COUNT(AVG_COUNT), .SUM_W(SUM_W)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.adc_sample (adc_sample),
		.fifo_full  (fifo_full),
		.fifo_push  (fifo_push),
		.fifo_wdata (fifo_wdata)
	);

	atfp_fifo #(.WIDTH(SUM_W)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fifo_push),
		.wdata  (fifo_wdata),
		.pop    (fifo_pop),
		.rdata  (fifo_rdata),
		.full   (fifo_full),
		.empty  (fifo_empty)
	);

	atfp_div #(.DIV_W(DIV_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quotient),
		.stat     (div_stat)
	);

	atfp_back #(.AVG_COUNT(AVG_COUNT), .SUM_W(SUM_W), .DIV_W(DIV_W)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.fifo_empty    (fifo_empty),
		.fifo_rdata    (fifo_rdata),
		.fifo_pop      (fifo_pop),
		.div_start     (div_start),
		.div_dividend  (div_dividend),
		.div_divisor   (div_divisor),
		.div_quotient  (div_quotient),
		.div_stat      (div_stat),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.reported_temp (reported_temp),
		.duty_compare  (duty_compare),
		.motor_running (motor_running),
		.pwm_enabled   (pwm_enabled)
	);
endmodule
`default_nettype wire
